@@ hdl/gspc_pkg.sv @@
// Shared types, curve constants and elaboration-time helpers of the gas ppm converter.
`default_nettype none

package gspc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CLEAN_AIR = 2'd0;
  localparam logic [1:0] CFG_ALARM     = 2'd1;

  // Gas selector codes
  localparam logic [2:0] GAS_LPG     = 3'd0;
  localparam logic [2:0] GAS_ALCOHOL = 3'd4;
  localparam logic [2:0] GAS_ALL     = 3'd5;
  localparam int         NUM_GASES   = 5;

  localparam logic [19:0] PPM_MAX   = 20'hFFFFF;
  localparam int          LOG_W     = 24;  // widest log operand (R0 register)
  localparam int          FRAC_BITS = 16;

  // log10(2) in Q30
  localparam logic signed [30:0] LOG10_2_Q30 = 31'sd323228497;

  // Curve offset b in Q16 and slope term log2(10)/m in Q16, per gas
  localparam logic signed [20:0] CURVE_B [NUM_GASES] = '{
    21'sd81962, 21'sd84596, 21'sd92574, 21'sd88418, 21'sd85871};
  localparam logic signed [20:0] CURVE_K [NUM_GASES] = '{
    -21'sd478645, -21'sd472207, -21'sd460213, -21'sd585225, -21'sd583175};

  // Control that travels with every item through the pipeline
  typedef struct packed {
    logic       valid;
    logic [2:0] gas;
    logic       last;
    logic       zero;
  } item_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] arg);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = arg;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-i) in Q30, by repeated square roots from 2.0
  function automatic logic [31:0] exp_root(input int i);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= i) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

  // Index of the most significant set bit
  function automatic logic [4:0] msb_index(input logic [LOG_W-1:0] x);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < LOG_W; i++) begin
      if (x[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ hdl/gas_sensor_ppm_converter.sv @@
// Top level of the gas ppm converter: log, curve and power pipeline.
//
//   channel  | direction | beat contents
//   s_       | in        | tdata: sample, gas_select
//   m_       | out       | tdata: ppm; tuser: gas_code, over_threshold, saturated; tlast
//   cfg_     | in        | cfg_index, cfg_data (clean_air_ratio, alarm_threshold)
//
// 41 register stages from input beat to output beat; one result leaves per cycle unless the output is stalled.
// A single-gas beat gives one result, an all-gases beat one per gas while the input is held off.
// The two 16-stage squaring and root-product chains set the latency.
// A stalled output holds every stage; reset empties the pipeline and loads register defaults.
`default_nettype none

module gas_sensor_ppm_converter #(
  parameter int ADC_WIDTH = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [ADC_WIDTH-1:0] sample, [ADC_WIDTH+2:ADC_WIDTH] gas_select, rest zero
  input  wire logic [((ADC_WIDTH+3+7)/8)*8-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [19:0] ppm, [23:20] zero
  output logic [23:0]                              m_tdata,
  // [2:0] gas_code, [3] over_threshold, [4] saturated
  output logic [4:0]                               m_tuser,
  output logic                                     m_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [23:0]                         cfg_data
);
  import gspc_pkg::*;

  localparam logic [ADC_WIDTH:0] FS = (ADC_WIDTH+1)'(1) << ADC_WIDTH;

  // Configuration registers
  logic [23:0] r0_reg;
  logic [19:0] thr_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_reg  <= 24'd65536;
      thr_reg <= 20'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLEAN_AIR: r0_reg  <= cfg_data;
        CFG_ALARM:     thr_reg <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the output beat is held
  logic adv;
  assign adv = !m_tvalid || m_tready;

  // Input stage and all-gases expansion
  logic                 exp_active;
  logic [2:0]           exp_gas;
  item_t                c0;
  logic [ADC_WIDTH-1:0] s0_sample;
  logic [ADC_WIDTH-1:0] in_sample;
  logic [2:0]           in_sel;
  logic                 in_all;

  assign in_sample = s_tdata[ADC_WIDTH-1:0];
  assign in_sel    = s_tdata[ADC_WIDTH+2:ADC_WIDTH];
  assign in_all    = in_sel inside {[GAS_ALL:3'd7]};
  assign s_tready  = adv && !exp_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.valid   <= 1'b0;
      exp_active <= 1'b0;
    end else if (adv) begin
      if (exp_active) begin
        c0.valid <= 1'b1;
        c0.gas   <= exp_gas;
        c0.last  <= (exp_gas == GAS_ALCOHOL);
        exp_gas  <= exp_gas + 3'd1;
        if (exp_gas == GAS_ALCOHOL) exp_active <= 1'b0;
      end else if (s_tvalid) begin
        c0.valid  <= 1'b1;
        c0.gas    <= in_all ? GAS_LPG : in_sel;
        c0.last   <= !in_all;
        c0.zero   <= (in_sample == '0);
        s0_sample <= in_sample;
        if (in_all) begin
          exp_active <= 1'b1;
          exp_gas    <= GAS_LPG + 3'd1;
        end
      end else begin
        c0.valid <= 1'b0;
      end
    end
  end

  // Log lanes: 0 is FS - s, 1 is s, 2 is R0. Index 0 holds the normalised operand.
  item_t       lg_c    [17];
  logic [30:0] lg_y    [17][3];
  logic [15:0] lg_frac [17][3];
  logic [4:0]  lg_e    [17][3];

  logic [LOG_W-1:0] nx [3];
  logic [4:0]       ne [3];

  assign nx[0] = LOG_W'(FS - {1'b0, s0_sample});
  assign nx[1] = c0.zero ? LOG_W'(1) : LOG_W'(s0_sample);
  assign nx[2] = (r0_reg == '0) ? LOG_W'(1) : r0_reg;

  always_comb begin
    for (int l = 0; l < 3; l++) ne[l] = msb_index(nx[l]);
  end

  // Normalise each operand to Q1.30
  always_ff @(posedge clk) begin
    if (rst) begin
      lg_c[0].valid <= 1'b0;
    end else if (adv) begin
      lg_c[0] <= c0;
      for (int l = 0; l < 3; l++) begin
        lg_y[0][l]    <= 31'(nx[l]) << (5'd30 - ne[l]);
        lg_e[0][l]    <= ne[l];
        lg_frac[0][l] <= 16'd0;
      end
    end
  end

  // One fraction bit per stage: square, then halve above two
  for (genvar st = 1; st <= 16; st++) begin : g_log
    logic [61:0] sq [3];
    logic [31:0] t  [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        sq[l] = lg_y[st-1][l] * lg_y[st-1][l];
        t[l]  = sq[l][61:30];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lg_c[st].valid <= 1'b0;
      end else if (adv) begin
        lg_c[st] <= lg_c[st-1];
        for (int l = 0; l < 3; l++) begin
          lg_y[st][l]    <= t[l][31] ? t[l][31:1] : t[l][30:0];
          lg_frac[st][l] <= {lg_frac[st-1][l][14:0], t[l][31]};
          lg_e[st][l]    <= lg_e[st-1][l];
        end
      end
    end
  end

  // Combine logs: log2 ratio in Q16
  item_t              c_sum;
  logic signed [23:0] l2;
  logic signed [23:0] lv [3];

  always_comb begin
    for (int l = 0; l < 3; l++) lv[l] = $signed({3'b000, lg_e[16][l], lg_frac[16][l]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_sum.valid <= 1'b0;
    end else if (adv) begin
      c_sum <= lg_c[16];
      l2    <= lv[0] - lv[1] - lv[2] + 24'sd1048576;
    end
  end

  // Scale to log10 in Q46
  item_t              c_lrm;
  logic signed [53:0] lr_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_lrm.valid <= 1'b0;
    end else if (adv) begin
      c_lrm   <= c_sum;
      lr_prod <= l2 * LOG10_2_Q30;
    end
  end

  // Round log10 to Q16 and subtract the curve offset
  item_t              c_d;
  logic signed [23:0] dval;
  logic [53:0]        lr_mag;
  logic [53:0]        lr_rnd;
  logic signed [23:0] lr;

  always_comb begin
    lr_mag = lr_prod[53] ? 54'(-lr_prod) : 54'(lr_prod);
    lr_rnd = (lr_mag + (54'd1 << 29)) >> 30;
    lr     = lr_prod[53] ? -$signed(lr_rnd[23:0]) : $signed(lr_rnd[23:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_d.valid <= 1'b0;
    end else if (adv) begin
      c_d  <= c_lrm;
      dval <= lr - 24'(CURVE_B[c_lrm.gas]);
    end
  end

  // Multiply by the slope term
  item_t              c_ek;
  logic signed [44:0] e_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ek.valid <= 1'b0;
    end else if (adv) begin
      c_ek   <= c_d;
      e_prod <= dval * CURVE_K[c_d.gas];
    end
  end

  // Round the exponent, clamp below, flag overflow above
  logic [44:0]        e_mag;
  logic [44:0]        e_rnd;
  logic signed [29:0] e_val;
  logic signed [29:0] e_clamp;
  logic [21:0]        e_u;

  always_comb begin
    e_mag   = e_prod[44] ? 45'(-e_prod) : 45'(e_prod);
    e_rnd   = (e_mag + (45'd1 << 15)) >> 16;
    e_val   = e_prod[44] ? -$signed(e_rnd[29:0]) : $signed(e_rnd[29:0]);
    e_clamp = (e_val < -30'sd2097152) ? -30'sd2097152 : e_val;
    e_u     = 22'(e_clamp + 30'sd2097152);
  end

  item_t       ex_c   [17];
  logic [31:0] ex_f   [17];
  logic [15:0] ex_fr  [17];
  logic [5:0]  ex_ip  [17];
  logic        ex_sat [17];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_c[0].valid <= 1'b0;
    end else if (adv) begin
      ex_c[0]   <= c_ek;
      ex_f[0]   <= 32'd1 << 30;
      ex_fr[0]  <= e_u[15:0];
      ex_ip[0]  <= e_u[21:16];
      ex_sat[0] <= (e_val >= 30'sd1310720);
    end
  end

  // Fold in one root factor per set fraction bit
  for (genvar st = 1; st <= 16; st++) begin : g_exp
    localparam logic [31:0] ROOT = exp_root(st);
    logic [63:0] pm;
    logic [63:0] pr;

    assign pm = ex_f[st-1] * ROOT;
    assign pr = (pm + (64'd1 << 29)) >> 30;

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_c[st].valid <= 1'b0;
      end else if (adv) begin
        ex_c[st]   <= ex_c[st-1];
        ex_f[st]   <= ex_fr[st-1][16-st] ? pr[31:0] : ex_f[st-1];
        ex_fr[st]  <= ex_fr[st-1];
        ex_ip[st]  <= ex_ip[st-1];
        ex_sat[st] <= ex_sat[st-1];
      end
    end
  end

  // Apply the integer part of the exponent with rounding, then saturate
  item_t       c_fin;
  logic [19:0] fin_ppm;
  logic        fin_sat;
  logic [5:0]  sh;
  logic [63:0] ppm_full;
  logic        sat_all;

  always_comb begin
    sh       = 6'd62 - ex_ip[16];
    ppm_full = ({32'd0, ex_f[16]} + (64'd1 << (sh - 6'd1))) >> sh;
    sat_all  = ex_c[16].zero || ex_sat[16] || (ppm_full > 64'(PPM_MAX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_fin.valid <= 1'b0;
    end else if (adv) begin
      c_fin   <= ex_c[16];
      fin_sat <= sat_all;
      fin_ppm <= sat_all ? PPM_MAX : ppm_full[19:0];
    end
  end

  // Output register with the alarm compare
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_fin.valid;
      m_tdata  <= {4'd0, fin_ppm};
      m_tuser  <= {fin_sat, (fin_ppm >= thr_reg), c_fin.gas};
      m_tlast  <= c_fin.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/gspc_checker.sv @@
// Port-level checks of the gas ppm converter, bound to the top level.
`default_nettype none

module gspc_checker #(
  parameter int ADC_WIDTH = 10
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [((ADC_WIDTH+3+7)/8)*8-1:0] s_tdata,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [23:0]                      m_tdata,
  input wire logic [4:0]                       m_tuser,
  input wire logic                             m_tlast
);
  import gspc_pkg::*;

  // Hold a stalled output beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed under stall");

  // Emit only real gas codes
  a_gas: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:0] <= GAS_ALCOHOL)
    else $error("gas code out of range");

  // Keep the padding of ppm clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:20] == 4'd0)
    else $error("ppm padding not zero");

  // Block new input while an all-gases beat expands
  a_expand: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[ADC_WIDTH+2:ADC_WIDTH] >= GAS_ALL) |=> !s_tready)
    else $error("input taken during all-gases expansion");

  // Empty output after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind gas_sensor_ppm_converter gspc_checker #(.ADC_WIDTH(ADC_WIDTH)) u_gspc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
  .m_tlast(m_tlast));

`default_nettype wire

@@ test/tb_gas_sensor_ppm_converter.sv @@
// Testbench for the gas ppm converter: directed and random stream traffic checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_gas_sensor_ppm_converter;
  import gspc_pkg::*;

  localparam int ADC_W     = 10;
  localparam int PIPE_WAIT = 80;   // cycles past the last result before a register write

  typedef struct {
    logic [2:0]  gas;
    logic [19:0] ppm;
    logic        over;
    logic        sat;
    logic        last;
  } conc_t;

  // Predicts the concentration beats of each accepted sample and checks the outputs
  class conc_scoreboard;
    conc_t       pending[$];
    logic [23:0] r0_reg  = 24'd65536;
    logic [19:0] thr_reg = 20'd1000;
    int          errors  = 0;

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint round_shift(longint v, int k);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + (64'd1 << (k - 1))) >> k;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // log2 in Q16 by repeated squaring of the normalised mantissa
    function longint log2_fix(longint unsigned x);
      int e;
      longint unsigned y;
      longint fbits;
      e = 0;
      fbits = 0;
      for (int i = 1; i < 32; i++) if ((x >> i) != 0) e = i;
      y = x << (30 - e);
      for (int i = 0; i < 16; i++) begin
        y = (y * y) >> 30;
        fbits = fbits << 1;
        if (y >= (64'd1 << 31)) begin
          y >>= 1;
          fbits |= 1;
        end
      end
      return (longint'(e) << 16) | fbits;
    endfunction

    // 2^e for a Q16 exponent, saturating at the 20-bit limit
    function void pow2_ppm(longint e, output logic [19:0] ppm, output logic sat);
      longint unsigned u, f, c, p;
      int ip, sh;
      f = 64'd1 << 30;
      c = 64'd1 << 31;
      if (e >= (longint'(20) << 16)) begin
        ppm = PPM_MAX;
        sat = 1'b1;
        return;
      end
      if (e < -(longint'(32) << 16)) e = -(longint'(32) << 16);
      u = e + (longint'(32) << 16);
      ip = int'(u >> 16);
      for (int i = 1; i <= 16; i++) begin
        c = root(c << 30);
        if ((u >> (16 - i)) & 1) f = (f * c + (64'd1 << 29)) >> 30;
      end
      sh = 62 - ip;
      p = (f + (64'd1 << (sh - 1))) >> sh;
      sat = (p > PPM_MAX);
      ppm = sat ? PPM_MAX : p[19:0];
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == CFG_CLEAN_AIR) r0_reg = val;
      else if (idx == CFG_ALARM) thr_reg = val[19:0];
    endfunction

    function void note_sample(logic [ADC_W-1:0] s, logic [2:0] sel);
      int first, count;
      longint l2, lr;
      longint unsigned r0;
      conc_t x;
      first = sel;
      count = 1;
      lr = 0;
      if (sel >= GAS_ALL) begin
        first = GAS_LPG;
        count = NUM_GASES;
      end
      r0 = (r0_reg == 0) ? 1 : r0_reg;
      if (s != 0) begin
        l2 = log2_fix((1 << ADC_W) - s) - log2_fix(s) - log2_fix(r0) + (longint'(16) << 16);
        lr = round_shift(l2 * longint'(LOG10_2_Q30), 30);
      end
      for (int k = 0; k < count; k++) begin
        x.gas = 3'(first + k);
        if (s == 0) begin
          x.ppm = PPM_MAX;
          x.sat = 1'b1;
        end else begin
          pow2_ppm(round_shift((lr - longint'(CURVE_B[first + k])) *
                               longint'(CURVE_K[first + k]), 16), x.ppm, x.sat);
        end
        x.over = (x.ppm >= thr_reg);
        x.last = (k + 1 == count);
        pending.push_back(x);
      end
    endfunction

    task check_beat(logic [23:0] tdata, logic [4:0] tuser, logic tlast);
      conc_t x;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      x = pending.pop_front();
      if (tuser[2:0] !== x.gas || tdata[19:0] !== x.ppm || tdata[23:20] !== 4'd0 ||
          tuser[3] !== x.over || tuser[4] !== x.sat || tlast !== x.last)
        report($sformatf("gas %0d ppm %0d ovr %0b sat %0b last %0b, want %0d %0d %0b %0b %0b",
                         tuser[2:0], tdata[19:0], tuser[3], tuser[4], tlast,
                         x.gas, x.ppm, x.over, x.sat, x.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_CLEAN_AIR;
  logic [23:0] cfg_data = '0;

  conc_scoreboard sb = new();
  bit no_idle = 1'b0;
  int stall_left = 0;

  gas_sensor_ppm_converter #(.ADC_WIDTH(ADC_W)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check result beats and stall the output at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      m_tready <= (stall_left == 0);
    end
  end

  task automatic send_sample(logic [ADC_W-1:0] s, logic [2:0] sel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, sel, s};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(s, sel);
  endtask

  // Hold off until every expected beat has left the pipeline
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  // Write one register, then drop cfg_valid and leave the channel idle
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [ADC_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ADC_W'($urandom_range(1, 8));
      default: return ADC_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [23:0] r0_set  [6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'd3000, 24'd900000};
    logic [23:0] thr_set [6] = '{24'd1000, 24'd0, 24'hFFFFF, 24'd1, 24'd50, 24'd20000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sample extremes against every selector, including the spare codes, then samples 1, 512 and 700
    for (int g = 0; g < 8; g++) send_sample('0, 3'(g));
    for (int g = 0; g < 8; g++) send_sample('1, 3'(g));
    send_sample(ADC_W'(1), GAS_ALL);
    send_sample(ADC_W'(512), GAS_LPG);
    send_sample(ADC_W'(700), GAS_ALCOHOL);
    drain();

    // Random phases under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) write_reg(CFG_ALARM, 24'($urandom_range(0, 20'hFFFFF)));
      write_reg(CFG_CLEAN_AIR, r0_set[ph]);
      write_reg(CFG_ALARM, thr_set[ph]);
      if (ph == 5) write_reg(CFG_CLEAN_AIR, 24'($urandom()));
      no_idle = (ph == 3);
      for (int n = 0; n < 50; n++)
        send_sample(rand_sample(), ($urandom_range(0, 3) == 0) ? GAS_ALL
                                                               : 3'($urandom_range(0, 7)));
      drain();
    end

    if (sb.pending.size() != 0) sb.report("expected beats left over");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gspc_pkg.sv
hdl/gas_sensor_ppm_converter.sv
hdl/gspc_checker.sv
test/tb_gas_sensor_ppm_converter.sv
